// File: hdl/mfa_pkg.sv
package mfa_pkg;

  // Operations of the shared iterative unit.
  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;
  localparam logic [1:0] OP_GCD = 2'd2;

  localparam int WORD_BITS = 64;

  // Command from the sequencer to the shared unit.
  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } mfa_cmd_t;

  // Result from the shared unit back to the sequencer.
  typedef struct packed {
    logic        done;
    logic [63:0] q;
    logic [63:0] r;
  } mfa_res_t;

endpackage

// File: hdl/mfa_unit.sv
module mfa_unit
  import mfa_pkg::*;
#(
  parameter int MUL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  mfa_cmd_t    cmd,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output mfa_res_t    res
);

  logic [63:0] acc;
  logic [63:0] x;
  logic [63:0] y;
  logic [5:0]  cnt;
  logic [6:0]  k;
  logic [1:0]  op_r;
  logic        busy;
  logic        done;
  logic [64:0] trial;
  logic        ge;

  localparam logic [5:0] MulLast = 6'(MUL_BITS - 1);
  localparam logic [5:0] DivLast = 6'(WORD_BITS - 1);

  // One restoring division step: shift in the next dividend bit and compare.
  assign trial = {acc, x[63]};
  assign ge    = trial >= {1'b0, y};

  // Shift-add multiply, restoring divide and binary GCD, one step a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        op_r <= cmd.op;
        busy <= 1'b1;
        cnt  <= '0;
        k    <= '0;
        acc  <= '0;
        x    <= a;
        y    <= b;
      end else if (busy) begin
        unique case (op_r)
          OP_MUL: begin
            if (y[0]) begin
              acc <= acc + x;
            end
            x   <= x << 1;
            y   <= y >> 1;
            cnt <= cnt + 6'd1;
            if (cnt == MulLast) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          OP_DIV: begin
            acc <= ge ? 64'(trial - {1'b0, y}) : trial[63:0];
            x   <= {x[62:0], ge};
            cnt <= cnt + 6'd1;
            if (cnt == DivLast) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          OP_GCD: begin
            priority if (x == '0) begin
              acc  <= y << k;
              busy <= 1'b0;
              done <= 1'b1;
            end else if (!x[0] && !y[0]) begin
              x <= x >> 1;
              y <= y >> 1;
              k <= k + 7'd1;
            end else if (!x[0]) begin
              x <= x >> 1;
            end else if (!y[0]) begin
              y <= y >> 1;
            end else if (x >= y) begin
              x <= x - y;
            end else begin
              y <= y - x;
            end
          end
          default: begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

  // Quotient comes from the shifted dividend, everything else from the accumulator.
  assign res.done = done;
  assign res.q    = (op_r == OP_DIV) ? x : acc;
  assign res.r    = acc;

endmodule

// File: hdl/mixed_fraction_adder.sv
// Channel   Dir  Fields (tdata, lowest bit first)
// s_axis    in   a_negative, a_whole, a_num, a_den, b_negative, b_whole, b_num, b_den
// m_axis    out  sum_negative, sum_whole, sum_num, sum_den, bad_denominator
//
// One request at a time through a shared shift-add / restoring-divide / GCD unit.
// Each request runs five multiplies and a divide, then the result is registered; a nonzero
// remainder adds a GCD and two more divides to reduce the fraction. A zero denominator
// goes from idle straight to the done state, which registers the flagged result.
// rst is synchronous and clears the sequencer and the output valid.
// The result waits in the output register while m_tready is low; the next
// request is taken once the sequencer is back to idle.
module mixed_fraction_adder
  import mfa_pkg::*;
#(
  parameter int FIELD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // a_negative, a_whole, a_num, a_den, b_negative, b_whole, b_num, b_den
  input  logic [((2 + 6 * FIELD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // sum_negative, sum_whole, sum_num, sum_den, bad_denominator
  output logic [103:0]                          m_tdata
);

  localparam int FB = FIELD_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MA1  = 4'd1;
  localparam logic [3:0] S_MA2  = 4'd2;
  localparam logic [3:0] S_MB1  = 4'd3;
  localparam logic [3:0] S_MB2  = 4'd4;
  localparam logic [3:0] S_MD   = 4'd5;
  localparam logic [3:0] S_DV1  = 4'd6;
  localparam logic [3:0] S_GCD  = 4'd7;
  localparam logic [3:0] S_DV2  = 4'd8;
  localparam logic [3:0] S_DV3  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]    state;
  logic          issue;
  logic          an;
  logic          bn;
  logic [FB-1:0] aw;
  logic [FB-1:0] anum;
  logic [FB-1:0] ad;
  logic [FB-1:0] bw;
  logic [FB-1:0] bnum;
  logic [FB-1:0] bd;
  logic [63:0]   ta;
  logic [63:0]   tb;
  logic [63:0]   mag;
  logic [63:0]   den;
  logic [63:0]   whole;
  logic [63:0]   rem;
  logic [63:0]   g;
  logic          neg;
  logic          bad;
  mfa_cmd_t      cmd;
  mfa_res_t      res;
  logic [63:0]   op_a;
  logic [63:0]   op_b;
  logic          accept;
  logic          in_an;
  logic          in_bn;
  logic [FB-1:0] in_aw;
  logic [FB-1:0] in_anum;
  logic [FB-1:0] in_ad;
  logic [FB-1:0] in_bw;
  logic [FB-1:0] in_bnum;
  logic [FB-1:0] in_bd;

  // Unpack the request.
  assign in_an   = s_tdata[0];
  assign in_aw   = s_tdata[1 +: FB];
  assign in_anum = s_tdata[1 + FB +: FB];
  assign in_ad   = s_tdata[1 + 2 * FB +: FB];
  assign in_bn   = s_tdata[1 + 3 * FB];
  assign in_bw   = s_tdata[2 + 3 * FB +: FB];
  assign in_bnum = s_tdata[2 + 4 * FB +: FB];
  assign in_bd   = s_tdata[2 + 5 * FB +: FB];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Operands for the shared unit in each step.
  always_comb begin
    cmd.start = issue;
    cmd.op    = OP_MUL;
    op_a      = '0;
    op_b      = '0;
    unique case (state)
      S_MA1: begin op_a = 64'(aw); op_b = 64'(ad); end
      S_MA2: begin op_a = ta; op_b = 64'(bd); end
      S_MB1: begin op_a = 64'(bw); op_b = 64'(bd); end
      S_MB2: begin op_a = tb; op_b = 64'(ad); end
      S_MD:  begin op_a = 64'(ad); op_b = 64'(bd); end
      S_DV1: begin cmd.op = OP_DIV; op_a = mag; op_b = den; end
      S_GCD: begin cmd.op = OP_GCD; op_a = rem; op_b = den; end
      S_DV2: begin cmd.op = OP_DIV; op_a = rem; op_b = g; end
      S_DV3: begin cmd.op = OP_DIV; op_a = den; op_b = g; end
      default: begin end
    endcase
  end

  mfa_unit #(
    .MUL_BITS(FIELD_BITS)
  ) u_unit (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .a   (op_a),
    .b   (op_b),
    .res (res)
  );

  // Sequencer: each step starts the unit once and waits for it to finish.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      issue    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      issue <= 1'b0;
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            an   <= in_an;
            bn   <= in_bn;
            aw   <= in_aw;
            anum <= in_anum;
            ad   <= in_ad;
            bw   <= in_bw;
            bnum <= in_bnum;
            bd   <= in_bd;
            if (in_ad == '0 || in_bd == '0) begin
              bad   <= 1'b1;
              state <= S_DONE;
            end else begin
              bad   <= 1'b0;
              issue <= 1'b1;
              state <= S_MA1;
            end
          end
        end
        S_MA1: if (res.done) begin
          ta    <= res.q + 64'(anum);
          issue <= 1'b1;
          state <= S_MA2;
        end
        S_MA2: if (res.done) begin
          ta    <= res.q;
          issue <= 1'b1;
          state <= S_MB1;
        end
        S_MB1: if (res.done) begin
          tb    <= res.q + 64'(bnum);
          issue <= 1'b1;
          state <= S_MB2;
        end
        S_MB2: if (res.done) begin
          tb    <= res.q;
          issue <= 1'b1;
          state <= S_MD;
        end
        S_MD: if (res.done) begin
          // Signed add of the cross products; a zero sum is positive.
          den <= res.q;
          if (an == bn) begin
            mag <= ta + tb;
            neg <= an && (ta + tb != '0);
          end else if (ta >= tb) begin
            mag <= ta - tb;
            neg <= an && (ta != tb);
          end else begin
            mag <= tb - ta;
            neg <= bn;
          end
          issue <= 1'b1;
          state <= S_DV1;
        end
        S_DV1: if (res.done) begin
          whole <= res.q;
          rem   <= res.r;
          if (res.r == '0) begin
            state <= S_DONE;
          end else begin
            issue <= 1'b1;
            state <= S_GCD;
          end
        end
        S_GCD: if (res.done) begin
          g     <= res.q;
          issue <= 1'b1;
          state <= S_DV2;
        end
        S_DV2: if (res.done) begin
          rem   <= res.q;
          issue <= 1'b1;
          state <= S_DV3;
        end
        S_DV3: if (res.done) begin
          den   <= res.q;
          state <= S_DONE;
        end
        S_DONE: begin
          // Hand the result over once the output register is free.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            if (bad) begin
              m_tdata <= {4'd0, 1'b1, 99'd0};
            end else begin
              m_tdata <= {4'd0, 1'b0, den[31:0], rem[31:0], whole[33:0], neg};
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A flagged result carries all-zero result fields.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[99] |-> m_tdata[98:0] == '0)
    else $error("bad denominator result with nonzero fields");

  // The unit finishes only while a request is in progress.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    res.done |-> state != S_IDLE && state != S_DONE)
    else $error("unit finished outside a request");

  // A taken request keeps the block busy in the next cycle.
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second request taken while busy");

endmodule

// File: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int IN_W = ((2 + 6 * FB + 7) / 8) * 8;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic        neg;
    logic [33:0] whole;
    logic [31:0] num;
    logic [31:0] den;
    logic        bad;
  } sum_t;

  // Scoreboard: predicts the reduced sum for each accepted request.
  class sum_board;
    sum_t pending[$];
    int   mismatches;

    function void note_request(logic [IN_W-1:0] d);
      logic        an, bn, neg;
      logic [63:0] aw, anm, ad, bw, bnm, bd, ta, tb, mag, den, whole, rem, p, q, r;
      sum_t        s;
      an  = d[0];
      aw  = d[16:1];
      anm = d[32:17];
      ad  = d[48:33];
      bn  = d[49];
      bw  = d[65:50];
      bnm = d[81:66];
      bd  = d[97:82];
      s = '0;
      if (ad == 0 || bd == 0) begin
        s.bad = 1'b1;
      end else begin
        ta = (aw * ad + anm) * bd;
        tb = (bw * bd + bnm) * ad;
        if (an == bn) begin
          mag = ta + tb;
          neg = an;
        end else if (ta >= tb) begin
          mag = ta - tb;
          neg = an;
        end else begin
          mag = tb - ta;
          neg = bn;
        end
        if (mag == 0) neg = 1'b0;
        den = ad * bd;
        whole = mag / den;
        rem = mag % den;
        if (rem != 0) begin
          // Euclid on remainder and denominator.
          p = rem;
          q = den;
          while (q != 0) begin
            r = p % q;
            p = q;
            q = r;
          end
          rem = rem / p;
          den = den / p;
        end
        s.neg = neg;
        s.whole = whole[33:0];
        s.num = rem[31:0];
        s.den = den[31:0];
      end
      pending.push_back(s);
    endfunction

    function void check_sum(logic [103:0] d);
      sum_t got, want;
      got.neg = d[0];
      got.whole = d[34:1];
      got.num = d[66:35];
      got.den = d[98:67];
      got.bad = d[99];
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected sum %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.neg !== want.neg || got.whole !== want.whole || got.num !== want.num ||
          got.den !== want.den || got.bad !== want.bad || d[103:100] !== 4'b0) begin
        mismatches++;
        if (mismatches <= 10) $display("Sum mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [103:0]    m_tdata;

  sum_board board = new();
  int  idle_pct = 14;
  int  quiet_cycles = 0;

  mixed_fraction_adder #(.FIELD_BITS(FB)) DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Accepted requests and sums are scored at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_request(s_tdata);
      if (m_tvalid && m_tready) board.check_sum(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver stalls at random.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [15:0] pick_field(int kind);
    case (kind)
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 12));
      default: return 16'($urandom);
    endcase
  endfunction

  // Requests are driven at the falling edge and held until taken.
  task automatic send_request(logic an, logic [15:0] aw, logic [15:0] anm, logic [15:0] ad,
                              logic bn, logic [15:0] bw, logic [15:0] bnm, logic [15:0] bd);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    s_tdata = IN_W'({bd, bnm, bw, bn, ad, anm, aw, an});
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic send_random();
    int m;
    m = $urandom_range(3);
    send_request(1'($urandom), pick_field($urandom_range(3)), pick_field(m),
                 ($urandom_range(19) == 0) ? 16'h0 : pick_field($urandom_range(1, 3)),
                 1'($urandom), pick_field($urandom_range(3)), pick_field(m),
                 ($urandom_range(19) == 0) ? 16'h0 : pick_field($urandom_range(1, 3)));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, signs, cancellation to zero, exact wholes, bad denominators.
    send_request(0, 0, 0, 1, 0, 0, 0, 1);
    send_request(1, 0, 0, 1, 1, 0, 0, 1);
    send_request(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 16'hFFFE);
    send_request(0, 3, 1, 2, 1, 3, 1, 2);
    send_request(1, 3, 1, 2, 0, 3, 1, 2);
    send_request(0, 1, 1, 3, 1, 2, 1, 6);
    send_request(1, 1, 1, 3, 0, 2, 1, 6);
    send_request(0, 0, 1, 2, 0, 0, 1, 2);
    send_request(0, 0, 7, 3, 0, 0, 5, 4);
    send_request(0, 5, 1, 0, 0, 1, 1, 1);
    send_request(1, 5, 1, 1, 1, 1, 1, 0);
    send_request(1, 16'hFFFF, 16'hFFFF, 0, 1, 16'hFFFF, 16'hFFFF, 0);
    send_request(0, 0, 16'hFFFF, 1, 1, 16'hFFFF, 0, 16'hFFFF);
    send_request(0, 16'hAAAA, 16'h5555, 16'hAAAA, 1, 16'h5555, 16'hAAAA, 16'h5555);

    // Random, with a middle stretch free of idling.
    for (int i = 0; i < 600; i++) begin
      if (i == 200) idle_pct = 0;
      if (i == 320) idle_pct = 14;
      if (i == 400) begin
        // Hold off until every expected sum has come back.
        while (board.pending.size() != 0) @(negedge clk);
      end
      send_random();
    end

    while (board.pending.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
